[rtl/atsm_pkg.sv]
// ----------------------------------------------------------------------------
// atsm_pkg
// shared types, constants and index math for the affine texture span mapper
// ----------------------------------------------------------------------------
package atsm_pkg;

  localparam int unsigned TEX_ADDR_W  = 16;
  localparam int unsigned TEX_DEPTH   = 65536;
  localparam int unsigned TEXEL_W     = 16;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned LOG2_W      = 4;
  localparam int unsigned OFFSET_W    = 6;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CMD_DEPTH   = 2;
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_TEX_LOG2    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT = 8'd1;

  localparam logic [LOG2_W-1:0] MIN_TEX_LOG2   = 4'd3;
  localparam logic [LOG2_W-1:0] RESET_TEX_LOG2 = 4'd3;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_SPAN = 1'b1
  } action_e;

  typedef enum logic {
    BK_IDLE,
    BK_SPAN
  } bk_state_e;

  // one queued command, load or span
  typedef struct packed {
    action_e                    action;
    logic [TEX_ADDR_W-1:0]      addr;
    logic signed [TEXEL_W-1:0]  data;
    logic [ACC_W-1:0]           acc;
    logic [ACC_W-1:0]           step;
    logic [LEN_W-1:0]           len;
    logic [LOG2_W-1:0]          log2_size;
    logic                       transparent;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [OFFSET_W-1:0]        offset;
    logic [TEX_ADDR_W-1:0]      index;
    logic signed [TEXEL_W-1:0]  texel;
    logic                       we;
    logic                       last;
  } pix_t;

  typedef struct packed {
    logic                       span_active;
    logic                       rd_pend;
    logic [OUT_CNT_W-1:0]       out_level;
  } bk_status_t;

  // high word of the packed accumulator: u above, integer bits of v below
  function automatic logic [COORD_W-1:0] pack_high(input logic [COORD_W-1:0] u,
                                                   input logic [COORD_W-1:0] v,
                                                   input logic [LOG2_W-1:0]  s);
    logic [COORD_W-1:0] low_mask;
    logic [4:0]         u_sh;
    low_mask = (32'd1 << s) - 32'd1;
    u_sh     = 5'd16 - {1'b0, s};
    return (u << u_sh) | ((v >> 16) & low_mask);
  endfunction

  // mask and rotate the high word into a linear texel index
  function automatic logic [TEX_ADDR_W-1:0] tex_index(input logic [COORD_W-1:0] hi,
                                                      input logic [LOG2_W-1:0]  s);
    logic [COORD_W-1:0] low_mask;
    logic [COORD_W-1:0] mask;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] rot;
    logic [5:0]         back_sh;
    back_sh  = 6'd32 - {2'b00, s};
    low_mask = (32'd1 << s) - 32'd1;
    mask     = (32'hFFFF_FFFF << back_sh) | low_mask;
    x        = hi & mask;
    rot      = (x << s) | (x >> back_sh);
    return rot[TEX_ADDR_W-1:0];
  endfunction

endpackage

[rtl/affine_texture_span_mapper.sv]
// ----------------------------------------------------------------------------
// affine_texture_span_mapper
// affine texture span walker over a square power-of-two texture
// ----------------------------------------------------------------------------
// Holds a 65536 x 16-bit texture memory. An item with action 0 writes one
// texel in the back end, with no result. An item with action 1 draws a
// span: u and v (16.16) are packed into one 64-bit accumulator and step, and
// each pixel masks and rotates the high word into a texel index, reads the
// texel and emits it, then one 64-bit add advances both coordinates. After a
// start step a span issues one pixel per cycle while the result queue has
// room, set by the accumulator add and the single texture read port; lengths
// above MAX_SPAN are clamped, length zero gives no results. A two-entry
// command queue separates the input side from the span walker and a
// four-entry result queue lets the consumer stall without losing pixels.
// Configuration writes are taken on the cfg channel (always ready) and must
// only happen while the block is idle. Texture memory is not cleared: read
// only texels you wrote.
// ----------------------------------------------------------------------------
module affine_texture_span_mapper #(
  parameter int unsigned MAX_SPAN     = 64,
  parameter int unsigned MAX_TEX_LOG2 = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input items
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   action_i,
  input  logic [atsm_pkg::TEX_ADDR_W-1:0]        texel_address_i,
  input  logic signed [atsm_pkg::TEXEL_W-1:0]    texel_data_i,
  input  logic signed [atsm_pkg::COORD_W-1:0]    v_start_i,
  input  logic signed [atsm_pkg::COORD_W-1:0]    u_start_i,
  input  logic signed [atsm_pkg::COORD_W-1:0]    u_step_i,
  input  logic signed [atsm_pkg::COORD_W-1:0]    v_step_i,
  input  logic [atsm_pkg::LEN_W-1:0]             span_length_i,
  // configuration writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [atsm_pkg::CFG_INDEX_W-1:0]       cfg_index_i,
  input  logic [atsm_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // result items
  output logic                                   empty,
  input  logic                                   pop,
  output logic [atsm_pkg::OFFSET_W-1:0]          pixel_offset_o,
  output logic [atsm_pkg::TEX_ADDR_W-1:0]        texture_index_o,
  output logic signed [atsm_pkg::TEXEL_W-1:0]    texel_value_o,
  output logic                                   write_enable_o,
  output logic                                   last_pixel_o
);

  // configuration registers
  logic [atsm_pkg::LOG2_W-1:0] tex_log2_q;
  logic                        transparent_q;

  // front to back command handoff
  atsm_pkg::cmd_t              cmd;
  logic                        cmd_empty;
  logic                        cmd_pop;

  atsm_pkg::pix_t              pix;
  atsm_pkg::bk_status_t        bk_status;

  // always ready: writes are registered
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_log2_q    <= atsm_pkg::RESET_TEX_LOG2;
      transparent_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        atsm_pkg::REG_TEX_LOG2: begin
          tex_log2_q <= cfg_data_i[atsm_pkg::LOG2_W-1:0];
        end
        atsm_pkg::REG_TRANSPARENT: begin
          transparent_q <= cfg_data_i[0];
        end
        default: begin
          // unknown register index, write dropped
        end
      endcase
    end
  end

  // front: clamps size and length, builds packed accumulator and step
  atsm_front #(
    .MAX_SPAN     (MAX_SPAN),
    .MAX_TEX_LOG2 (MAX_TEX_LOG2)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .action_i        (action_i),
    .texel_address_i (texel_address_i),
    .texel_data_i    (texel_data_i),
    .v_start_i       (v_start_i),
    .u_start_i       (u_start_i),
    .u_step_i        (u_step_i),
    .v_step_i        (v_step_i),
    .span_length_i   (span_length_i),
    .tex_log2_i      (tex_log2_q),
    .transparent_i   (transparent_q),
    .cmd_o           (cmd),
    .cmd_empty_o     (cmd_empty),
    .cmd_pop_i       (cmd_pop)
  );

  // back: texel writes, span walk, texel fetch, result queue
  atsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .pix_o       (pix),
    .status_o    (bk_status)
  );

  assign pixel_offset_o  = pix.offset;
  assign texture_index_o = pix.index;
  assign texel_value_o   = pix.texel;
  assign write_enable_o  = pix.we;
  assign last_pixel_o    = pix.last;

`ifndef SYNTHESIS
  // queued results plus the read in flight never exceed the result queue
  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, bk_status.out_level} + {{atsm_pkg::OUT_CNT_W{1'b0}}, bk_status.rd_pend})
      <= (atsm_pkg::OUT_CNT_W + 1)'(atsm_pkg::OUT_DEPTH))
    else $error("result queue credit exceeded");

  // a texel read in flight lands in the result queue on the next cycle
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.rd_pend |=> !empty)
    else $error("texel read did not reach the result queue");

  // zero texels in transparent mode are never marked for writing
  a_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && transparent_q && (texel_value_o == '0) && $stable(transparent_q)
      && $past(transparent_q)) |-> !write_enable_o)
    else $error("transparent texel marked for write");
`endif

endmodule

[rtl/atsm_ram.sv]
// ----------------------------------------------------------------------------
// atsm_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module atsm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/atsm_fifo.sv]
// ----------------------------------------------------------------------------
// atsm_fifo
// small register queue with fill level
// ----------------------------------------------------------------------------
module atsm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             wdata_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             rdata_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   level_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign level_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/atsm_front.sv]
// ----------------------------------------------------------------------------
// atsm_front
// accepts items, classifies load or span, packs coordinates into commands
// ----------------------------------------------------------------------------
module atsm_front #(
  parameter int unsigned MAX_SPAN     = 64,
  parameter int unsigned MAX_TEX_LOG2 = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic                                   action_i,
  input  logic [atsm_pkg::TEX_ADDR_W-1:0]        texel_address_i,
  input  logic signed [atsm_pkg::TEXEL_W-1:0]    texel_data_i,
  input  logic signed [atsm_pkg::COORD_W-1:0]    v_start_i,
  input  logic signed [atsm_pkg::COORD_W-1:0]    u_start_i,
  input  logic signed [atsm_pkg::COORD_W-1:0]    u_step_i,
  input  logic signed [atsm_pkg::COORD_W-1:0]    v_step_i,
  input  logic [atsm_pkg::LEN_W-1:0]             span_length_i,
  input  logic [atsm_pkg::LOG2_W-1:0]            tex_log2_i,
  input  logic                                   transparent_i,
  output atsm_pkg::cmd_t                         cmd_o,
  output logic                                   cmd_empty_o,
  input  logic                                   cmd_pop_i
);

  localparam logic [atsm_pkg::LOG2_W-1:0] MaxLog2 = atsm_pkg::LOG2_W'(MAX_TEX_LOG2);
  localparam logic [atsm_pkg::LEN_W-1:0]  MaxLen  = atsm_pkg::LEN_W'(MAX_SPAN);

  logic [atsm_pkg::LOG2_W-1:0]                    s;
  atsm_pkg::cmd_t                                 cmd_in;
  logic [$clog2(atsm_pkg::CMD_DEPTH+1)-1:0]       cmd_level;

  // clamp texture size into the supported range
  always_comb begin
    if (tex_log2_i < atsm_pkg::MIN_TEX_LOG2) begin
      s = atsm_pkg::MIN_TEX_LOG2;
    end else if (tex_log2_i > MaxLog2) begin
      s = MaxLog2;
    end else begin
      s = tex_log2_i;
    end
  end

  always_comb begin
    cmd_in.action      = atsm_pkg::action_e'(action_i);
    cmd_in.addr        = texel_address_i;
    cmd_in.data        = texel_data_i;
    cmd_in.acc         = {atsm_pkg::pack_high(u_start_i, v_start_i, s),
                          v_start_i[15:0], 16'h0000};
    cmd_in.step        = {atsm_pkg::pack_high(u_step_i, v_step_i, s),
                          v_step_i[15:0], 16'h0000};
    cmd_in.len         = (span_length_i > MaxLen) ? MaxLen : span_length_i;
    cmd_in.log2_size   = s;
    cmd_in.transparent = transparent_i;
  end

  atsm_fifo #(
    .WIDTH ($bits(atsm_pkg::cmd_t)),
    .DEPTH (atsm_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o),
    .level_o (cmd_level)
  );

endmodule

[rtl/atsm_back.sv]
// ----------------------------------------------------------------------------
// atsm_back
// executes commands: texel writes and per-pixel span walk with texel fetch
// ----------------------------------------------------------------------------
module atsm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  atsm_pkg::cmd_t       cmd_i,
  input  logic                 cmd_empty_i,
  output logic                 cmd_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output atsm_pkg::pix_t       pix_o,
  output atsm_pkg::bk_status_t status_o
);

  atsm_pkg::bk_state_e                   state_q, state_d;
  logic [atsm_pkg::ACC_W-1:0]            acc_q, acc_d;
  logic [atsm_pkg::ACC_W-1:0]            step_q, step_d;
  logic [atsm_pkg::LEN_W-1:0]            len_q, len_d;
  logic [atsm_pkg::LEN_W-1:0]            cnt_q, cnt_d;
  logic [atsm_pkg::LOG2_W-1:0]           s_q, s_d;
  logic                                  tr_q, tr_d;
  logic                                  pend_q, pend_d;
  logic [atsm_pkg::OFFSET_W-1:0]         m_offset_q, m_offset_d;
  logic [atsm_pkg::TEX_ADDR_W-1:0]       m_index_q, m_index_d;
  logic                                  m_last_q, m_last_d;

  logic                                  ram_we, ram_re;
  logic [atsm_pkg::TEX_ADDR_W-1:0]       ram_raddr;
  logic [atsm_pkg::TEXEL_W-1:0]          ram_rdata;
  logic [atsm_pkg::OUT_CNT_W-1:0]        out_level;
  logic                                  out_full;
  logic                                  issue_ok;
  logic                                  is_last;
  atsm_pkg::pix_t                        pix_in;

  assign ram_raddr = atsm_pkg::tex_index(acc_q[atsm_pkg::ACC_W-1:atsm_pkg::COORD_W], s_q);
  // credit check counts the read still in flight
  assign issue_ok  = ({1'b0, out_level} + {{atsm_pkg::OUT_CNT_W{1'b0}}, pend_q})
                     < (atsm_pkg::OUT_CNT_W + 1)'(atsm_pkg::OUT_DEPTH);
  assign is_last   = ((cnt_q + 1'b1) == len_q);

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    step_d     = step_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    s_d        = s_q;
    tr_d       = tr_q;
    pend_d     = 1'b0;
    m_offset_d = m_offset_q;
    m_index_d  = m_index_q;
    m_last_d   = m_last_q;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state_q)
      atsm_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.action == atsm_pkg::ACT_LOAD) begin
            ram_we = 1'b1;
          end else if (cmd_i.len != '0) begin
            acc_d   = cmd_i.acc;
            step_d  = cmd_i.step;
            len_d   = cmd_i.len;
            cnt_d   = '0;
            s_d     = cmd_i.log2_size;
            tr_d    = cmd_i.transparent;
            state_d = atsm_pkg::BK_SPAN;
          end
        end
      end
      atsm_pkg::BK_SPAN: begin
        if (issue_ok) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          m_offset_d = cnt_q[atsm_pkg::OFFSET_W-1:0];
          m_index_d  = ram_raddr;
          m_last_d   = is_last;
          acc_d      = acc_q + step_q;
          cnt_d      = cnt_q + 1'b1;
          if (is_last) begin
            state_d = atsm_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_d = atsm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atsm_pkg::BK_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    step_q     <= step_d;
    len_q      <= len_d;
    cnt_q      <= cnt_d;
    s_q        <= s_d;
    tr_q       <= tr_d;
    m_offset_q <= m_offset_d;
    m_index_q  <= m_index_d;
    m_last_q   <= m_last_d;
  end

  atsm_ram #(
    .WIDTH (atsm_pkg::TEXEL_W),
    .DEPTH (atsm_pkg::TEX_DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    pix_in.offset = m_offset_q;
    pix_in.index  = m_index_q;
    pix_in.texel  = ram_rdata;
    pix_in.we     = !tr_q || (ram_rdata != '0);
    pix_in.last   = m_last_q;
  end

  atsm_fifo #(
    .WIDTH ($bits(atsm_pkg::pix_t)),
    .DEPTH (atsm_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pend_q),
    .wdata_i (pix_in),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (pix_o),
    .empty_o (empty_o),
    .level_o (out_level)
  );

  assign status_o.span_active = (state_q == atsm_pkg::BK_SPAN) && !out_full;
  assign status_o.rd_pend     = pend_q;
  assign status_o.out_level   = out_level;

endmodule

[bench/affine_texture_span_mapper_tb.sv]
// ----------------------------------------------------------------------------
// affine_texture_span_mapper_tb
// self-checking bench for the affine texture span mapper
// ----------------------------------------------------------------------------
// Walks a short table of hand-picked loads, spans and register writes, then
// runs several random phases under different texture sizes and transparency
// settings. Every accepted item updates a local texture shadow and packed
// accumulator walk, and the resulting pixels are queued and compared field by
// field as they are popped. Before each span the bench loads any texel that
// the span would read and that was never written.
// ----------------------------------------------------------------------------
module affine_texture_span_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SPAN_LIMIT    = 64;
  localparam int unsigned TEX_LOG2_TOP  = 8;
  localparam int unsigned SETTLE_CYCLES = 16;    // covers loads still in the pipe
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned STALL_LIMIT   = 3000;  // cycles with no handshake at all
  localparam int unsigned PHASES        = 7;
  localparam int unsigned PHASE_ITEMS   = 28;
  localparam int unsigned HOLD_PHASE    = 1;
  localparam int unsigned STEADY_PHASE  = 3;
  localparam logic [atsm_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hA5;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_SPAN
  } row_kind_e;

  // one line of the directed table
  typedef struct {
    row_kind_e                        kind;
    logic [atsm_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [atsm_pkg::CFG_DATA_W-1:0]  reg_value;
    logic [15:0]                      addr;
    logic [15:0]                      data;
    logic [31:0]                      v0;
    logic [31:0]                      u0;
    logic [31:0]                      du;
    logic [31:0]                      dv;
    logic [6:0]                       len;
    bit                               typed;   // want holds the single pixel of this span
    atsm_pkg::pix_t                   want;
  } stim_row_t;

  // dut ports
  logic                             clk_i;
  logic                             rst_ni;
  logic                             push;
  logic                             full;
  logic                             action_i;
  logic [15:0]                      texel_address_i;
  logic signed [15:0]               texel_data_i;
  logic signed [31:0]               v_start_i;
  logic signed [31:0]               u_start_i;
  logic signed [31:0]               u_step_i;
  logic signed [31:0]               v_step_i;
  logic [6:0]                       span_length_i;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [atsm_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [atsm_pkg::CFG_DATA_W-1:0]  cfg_data_i;
  logic                             empty;
  logic                             pop;
  logic [5:0]                       pixel_offset_o;
  logic [15:0]                      texture_index_o;
  logic signed [15:0]               texel_value_o;
  logic                             write_enable_o;
  logic                             last_pixel_o;

  // mirror of the block: texture contents and register values
  logic [15:0]            tex_shadow [65536];
  bit                     tex_loaded [65536];
  logic [3:0]             cfg_log2;
  logic                   cfg_transparent;

  // texel indices of the span being issued, in pixel order
  logic [15:0]            span_slots [$];
  // pixels still to come out of the block, oldest first
  atsm_pkg::pix_t         pixel_q [$];

  stim_row_t              dir_rows [$];
  int unsigned            items_sent;
  int unsigned            fault_count;
  bit                     steady;     // no idling on either side
  bit                     hold_req;   // asks the result side for a long hold-off
  int unsigned            stall_cycles;

  logic [3:0]             plan_log2   [PHASES] = '{4'd3, 4'd5, 4'd8, 4'd0, 4'd15, 4'd6, 4'd2};
  logic                   plan_transp [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  affine_texture_span_mapper u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .texel_address_i (texel_address_i),
    .texel_data_i    (texel_data_i),
    .v_start_i       (v_start_i),
    .u_start_i       (u_start_i),
    .u_step_i        (u_step_i),
    .v_step_i        (v_step_i),
    .span_length_i   (span_length_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .empty           (empty),
    .pop             (pop),
    .pixel_offset_o  (pixel_offset_o),
    .texture_index_o (texture_index_o),
    .texel_value_o   (texel_value_o),
    .write_enable_o  (write_enable_o),
    .last_pixel_o    (last_pixel_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  // texture size actually used, out-of-range settings are clamped
  function automatic int unsigned eff_log2();
    if (cfg_log2 < atsm_pkg::MIN_TEX_LOG2) return atsm_pkg::MIN_TEX_LOG2;
    if (cfg_log2 > TEX_LOG2_TOP) return TEX_LOG2_TOP;
    return cfg_log2;
  endfunction

  // upper accumulator word: u shifted up, integer bits of v at the bottom
  function automatic logic [31:0] coord_high(input logic [31:0] u, input logic [31:0] v,
                                             input int unsigned s);
    return (u << (16 - s)) | ((v >> 16) & ((32'd1 << s) - 32'd1));
  endfunction

  // walk the packed accumulator and record the texel index of every pixel
  function automatic void trace_span(input logic [31:0] v0, input logic [31:0] u0,
                                     input logic [31:0] du, input logic [31:0] dv,
                                     input logic [6:0] len);
    int unsigned s;
    int unsigned n;
    logic [63:0] acc;
    logic [63:0] stride;
    logic [31:0] hi;
    s      = eff_log2();
    n      = (len > SPAN_LIMIT) ? SPAN_LIMIT : len;
    acc    = {coord_high(u0, v0, s), v0 << 16};
    stride = {coord_high(du, dv, s), dv << 16};
    span_slots.delete();
    repeat (n) begin
      hi = acc[63:32];
      // v bits land above u bits: row-major index into the square texture
      span_slots.push_back(16'(((hi & ((32'd1 << s) - 32'd1)) << s) | (hi >> (32 - s))));
      acc += stride;
    end
  endfunction

  // turn the traced indices into expected pixels
  function automatic void expect_span();
    atsm_pkg::pix_t p;
    for (int i = 0; i < span_slots.size(); i++) begin
      p.offset = i[5:0];
      p.index  = span_slots[i];
      p.texel  = tex_shadow[span_slots[i]];
      p.we     = !cfg_transparent || (p.texel != 16'sd0);
      p.last   = (i == span_slots.size() - 1);
      pixel_q.push_back(p);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_pixel();
    atsm_pkg::pix_t want;
    if (pixel_q.size() == 0) begin
      $error("result with no expectation: offset %0d index %0d", pixel_offset_o,
             texture_index_o);
      fault_count++;
      return;
    end
    want = pixel_q.pop_front();
    if (pixel_offset_o !== want.offset) begin
      $error("pixel_offset: expected %0d, got %0d", want.offset, pixel_offset_o);
      fault_count++;
    end
    if (texture_index_o !== want.index) begin
      $error("texture_index: expected %0d, got %0d", want.index, texture_index_o);
      fault_count++;
    end
    if (texel_value_o !== want.texel) begin
      $error("texel_value: expected %0d, got %0d", want.texel, texel_value_o);
      fault_count++;
    end
    if (write_enable_o !== want.we) begin
      $error("write_enable: expected %0d, got %0d", want.we, write_enable_o);
      fault_count++;
    end
    if (last_pixel_o !== want.last) begin
      $error("last_pixel: expected %0d, got %0d", want.last, last_pixel_o);
      fault_count++;
    end
  endfunction

  // ---------------------------------------------------------------- directed table

  function automatic stim_row_t blank_row(input row_kind_e kind);
    stim_row_t r;
    r.kind      = kind;
    r.reg_index = '0;
    r.reg_value = '0;
    r.addr      = '0;
    r.data      = '0;
    r.v0        = '0;
    r.u0        = '0;
    r.du        = '0;
    r.dv        = '0;
    r.len       = '0;
    r.typed     = 1'b0;
    r.want      = '0;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input logic [atsm_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [atsm_pkg::CFG_DATA_W-1:0] value);
    stim_row_t r;
    r           = blank_row(ROW_CFG);
    r.reg_index = idx;
    r.reg_value = value;
    return r;
  endfunction

  function automatic stim_row_t row_load(input logic [15:0] addr, input logic [15:0] data);
    stim_row_t r;
    r      = blank_row(ROW_LOAD);
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t row_span(input logic [31:0] v0, input logic [31:0] u0,
                                         input logic [31:0] du, input logic [31:0] dv,
                                         input logic [6:0] len);
    stim_row_t r;
    r     = blank_row(ROW_SPAN);
    r.v0  = v0;
    r.u0  = u0;
    r.du  = du;
    r.dv  = dv;
    r.len = len;
    return r;
  endfunction

  // one-pixel span whose result is written down by hand
  function automatic stim_row_t row_pixel(input logic [31:0] v0, input logic [31:0] u0,
                                          input logic [15:0] index, input logic [15:0] texel,
                                          input logic we);
    stim_row_t r;
    r             = row_span(v0, u0, 32'd0, 32'd0, 7'd1);
    r.typed       = 1'b1;
    r.want.offset = '0;
    r.want.index  = index;
    r.want.texel  = texel;
    r.want.we     = we;
    r.want.last   = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------- input side

  // texel values, zero often enough to exercise transparency
  function automatic logic [15:0] random_texel();
    if ($urandom_range(99) < 20) return 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic logic [6:0] pick_span_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 7'd0;
    if (r < 70) return 7'($urandom_range(1, 16));
    if (r < 85) return 7'($urandom_range(17, 64));
    if (r < 92) return 7'd64;
    return 7'($urandom_range(65, 127));   // clamps to a full span
  endfunction

  // offer one item and wait until it is taken, then update the mirror
  task automatic issue_item(input atsm_pkg::action_e act, input logic [15:0] addr,
                            input logic [15:0] data, input logic [31:0] v0,
                            input logic [31:0] u0, input logic [31:0] du,
                            input logic [31:0] dv, input logic [6:0] len,
                            input bit typed, input atsm_pkg::pix_t want);
    if (!steady && $urandom_range(99) < 10) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    action_i        <= act;
    texel_address_i <= addr;
    texel_data_i    <= data;
    v_start_i       <= v0;
    u_start_i       <= u0;
    u_step_i        <= du;
    v_step_i        <= dv;
    span_length_i   <= len;
    push            <= 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (act == atsm_pkg::ACT_LOAD) begin
      tex_shadow[addr] = data;
      tex_loaded[addr] = 1'b1;
    end else if (typed) begin
      pixel_q.push_back(want);
    end else begin
      expect_span();
    end
  endtask

  // load every texel the span will touch that holds nothing yet, then send it
  task automatic issue_span(input logic [31:0] v0, input logic [31:0] u0,
                            input logic [31:0] du, input logic [31:0] dv,
                            input logic [6:0] len, input bit typed,
                            input atsm_pkg::pix_t want);
    trace_span(v0, u0, du, dv, len);
    for (int k = 0; k < span_slots.size(); k++) begin
      if (!tex_loaded[span_slots[k]])
        issue_item(atsm_pkg::ACT_LOAD, span_slots[k], random_texel(), $urandom, $urandom,
                   $urandom, $urandom, 7'($urandom), 1'b0, '0);
    end
    issue_item(atsm_pkg::ACT_SPAN, 16'($urandom), 16'($urandom), v0, u0, du, dv, len,
               typed, want);
  endtask

  // stop offering items and wait until the block has nothing left to say
  task automatic settle();
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only ever done once the block is quiet
  task automatic write_reg(input logic [atsm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [atsm_pkg::CFG_DATA_W-1:0] value);
    settle();
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == atsm_pkg::REG_TEX_LOG2) cfg_log2 = value[3:0];
    else if (idx == atsm_pkg::REG_TRANSPARENT) cfg_transparent = value[0];
  endtask

  task automatic issue_random_item();
    int unsigned side;
    logic [15:0] addr;
    side = 1 << eff_log2();
    if ($urandom_range(99) < 25) begin
      // plain load, either anywhere or inside the active texture
      addr = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, side * side - 1));
      issue_item(atsm_pkg::ACT_LOAD, addr, random_texel(), $urandom, $urandom, $urandom,
                 $urandom, 7'($urandom), 1'b0, '0);
    end else if ($urandom_range(99) < 70) begin
      // typical scanline: start inside the texture, steps within two texels
      issue_span(($urandom_range(0, side - 1) << 16) | $urandom_range(0, 16'hFFFF),
                 ($urandom_range(0, side - 1) << 16) | $urandom_range(0, 16'hFFFF),
                 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000,
                 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000,
                 pick_span_length(), 1'b0, '0);
    end else begin
      // anything goes, coordinates wrap through the mask
      issue_span($urandom, $urandom, $urandom, $urandom, pick_span_length(), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_side
    int unsigned hold_left;
    pop       = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_pixel();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        // the block fills up and has to stall its input meanwhile
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : input_side
    int unsigned phase_base;
    rst_ni          = 1'b0;
    push            = 1'b0;
    action_i        = atsm_pkg::ACT_LOAD;
    texel_address_i = '0;
    texel_data_i    = '0;
    v_start_i       = '0;
    u_start_i       = '0;
    u_step_i        = '0;
    v_step_i        = '0;
    span_length_i   = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    cfg_log2        = atsm_pkg::RESET_TEX_LOG2;
    cfg_transparent = 1'b0;
    items_sent      = 0;
    fault_count     = 0;
    steady          = 1'b0;
    hold_req        = 1'b0;
    foreach (tex_loaded[i]) tex_loaded[i] = 1'b0;

    // reset values, 8x8 texture: index is v * 8 + u
    dir_rows.push_back(row_load(16'd0, 16'h1234));
    dir_rows.push_back(row_load(16'd63, 16'h7FFF));
    dir_rows.push_back(row_load(16'd9, 16'h8000));
    dir_rows.push_back(row_load(16'd1, 16'h0000));
    dir_rows.push_back(row_pixel(32'h0000_0000, 32'h0000_0000, 16'd0, 16'h1234, 1'b1));
    dir_rows.push_back(row_pixel(32'h0007_0000, 32'h0007_0000, 16'd63, 16'h7FFF, 1'b1));
    dir_rows.push_back(row_pixel(32'h0001_0000, 32'h0001_0000, 16'd9, 16'h8000, 1'b1));
    // zero texel still written while transparency is off
    dir_rows.push_back(row_pixel(32'h0000_0000, 32'h0001_0000, 16'd1, 16'h0000, 1'b1));
    // zero length gives nothing
    dir_rows.push_back(row_span(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0, 7'd0));
    // full span wrapping along one row
    dir_rows.push_back(row_span(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0, 7'd64));
    // coordinate extremes with over-long lengths that clamp
    dir_rows.push_back(row_span(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                7'd127));
    dir_rows.push_back(row_span(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                7'd65));
    // fractional steps, v carries into the high word
    dir_rows.push_back(row_span(32'h0000_FFFF, 32'h0000_8000, 32'h0000_4000, 32'h0000_C000,
                                7'd20));
    // transparency suppresses the zero texel only
    dir_rows.push_back(row_cfg(atsm_pkg::REG_TRANSPARENT, 32'd1));
    dir_rows.push_back(row_pixel(32'h0000_0000, 32'h0001_0000, 16'd1, 16'h0000, 1'b0));
    dir_rows.push_back(row_pixel(32'h0000_0000, 32'h0000_0000, 16'd0, 16'h1234, 1'b1));
    // largest texture, far corner
    dir_rows.push_back(row_cfg(atsm_pkg::REG_TEX_LOG2, 32'd8));
    dir_rows.push_back(row_load(16'hFFFF, 16'h5A5A));
    dir_rows.push_back(row_pixel(32'h00FF_0000, 32'h00FF_0000, 16'hFFFF, 16'h5A5A, 1'b1));
    dir_rows.push_back(row_span(32'h00FF_8000, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000,
                                7'd8));
    // sizes below and above the legal range clamp to the ends
    dir_rows.push_back(row_cfg(atsm_pkg::REG_TEX_LOG2, 32'd0));
    dir_rows.push_back(row_span(32'h1234_5678, 32'h8765_4321, 32'h0000_9000, 32'hFFFF_3000,
                                7'd10));
    dir_rows.push_back(row_cfg(atsm_pkg::REG_TEX_LOG2, 32'd15));
    dir_rows.push_back(row_span(32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'hFFFE_8000, 32'h0001_8000,
                                7'd10));
    // unmapped register index is ignored
    dir_rows.push_back(row_cfg(REG_UNMAPPED, 32'hFFFF_FFFF));
    dir_rows.push_back(row_cfg(atsm_pkg::REG_TRANSPARENT, 32'd0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_CFG: begin
          write_reg(dir_rows[r].reg_index, dir_rows[r].reg_value);
        end
        ROW_LOAD: begin
          issue_item(atsm_pkg::ACT_LOAD, dir_rows[r].addr, dir_rows[r].data, 32'd0, 32'd0,
                     32'd0, 32'd0, 7'd0, 1'b0, '0);
        end
        default: begin
          issue_span(dir_rows[r].v0, dir_rows[r].u0, dir_rows[r].du, dir_rows[r].dv,
                     dir_rows[r].len, dir_rows[r].typed, dir_rows[r].want);
        end
      endcase
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      steady = 1'b0;
      write_reg(atsm_pkg::REG_TEX_LOG2, {28'($urandom), plan_log2[ph]});
      write_reg(atsm_pkg::REG_TRANSPARENT, {31'($urandom), plan_transp[ph]});
      if (ph % 2 == 1) write_reg(8'($urandom_range(2, 255)), $urandom);
      steady = (ph == STEADY_PHASE);
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) issue_random_item();
    end

    settle();
    if (fault_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
